>>> hdl/fhd_pkg.sv
// Shared widths, character constants and helper functions for the file name hash block.
package fhd_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 32;
    localparam int PART_W = 24;

    localparam logic [BYTE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [BYTE_W-1:0] t_char;
    typedef logic [1:0]        t_pos;

    // Map a to z onto A to Z; every other byte passes unchanged.
    function automatic t_char to_upper(input t_char c);
        if (c >= LOWER_A && c <= LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // Rotate a hash left by one bit.
    function automatic t_hash rotl1(input t_hash v);
        return {v[HASH_W-2:0], v[HASH_W-1]};
    endfunction

endpackage

>>> hdl/filename_hash_dual.sv
// Top level of the dual rotate-add file name hash.
//
// The block takes a file name one byte per item and, on the item marked last,
// delivers two 32-bit hashes: one over little-endian 4-byte words (a short final
// word is zero-padded) and one over single bytes, both folded in as
// rotate-left-by-one plus value. Letters a to z are upper-cased first, and bytes
// beyond the first MAX_NAME_CHARS of a name are ignored, though their last flag
// still closes the name. The block accepts one byte every clock cycle; each byte
// passes through one adder per hash between the state registers and the result
// register, and the result appears in the cycle after the last byte is accepted.
// A result register sits between the two sides, so input keeps flowing as long
// as each finished result is taken; while a result waits at a stalled output,
// the input waits too.
module filename_hash_dual #(
    parameter int MAX_NAME_CHARS = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_name_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fhd_pkg::t_hash        o_word_hash,
    output fhd_pkg::t_hash        o_byte_hash
);
    import fhd_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_CHARS);
    localparam t_pos POS_LAST = 2'd3;

    // Running state of the name in progress.
    t_hash              r_word_acc, n_word_acc;
    t_hash              r_byte_acc, n_byte_acc;
    logic [PART_W-1:0]  r_partial, n_partial;
    t_pos               r_pos, n_pos;
    logic [LEN_W-1:0]   r_len, n_len;

    // Result register.
    logic               r_out_valid;
    t_hash              r_word_hash, n_word_hash;
    t_hash              r_byte_hash;

    logic  in_accept;
    logic  take;
    t_char ch;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign take        = r_len < LEN_MAX;
    assign ch          = to_upper(i_name_byte);

    assign o_out_valid = r_out_valid;
    assign o_word_hash = r_word_hash;
    assign o_byte_hash = r_byte_hash;

    // Fold the byte into both hashes and into the unfinished word.
    always_comb begin
        n_word_acc = r_word_acc;
        n_byte_acc = r_byte_acc;
        n_partial  = r_partial;
        n_pos      = r_pos;
        n_len      = r_len;
        if (take) begin
            n_len      = r_len + 1'b1;
            n_byte_acc = rotl1(r_byte_acc) + t_hash'(ch);
            case (r_pos)
                2'd0:    n_partial[7:0]   = ch;
                2'd1:    n_partial[15:8]  = ch;
                2'd2:    n_partial[23:16] = ch;
                default: n_partial        = '0;
            endcase
            if (r_pos == POS_LAST) begin
                n_word_acc = rotl1(r_word_acc) + {ch, r_partial};
                n_pos      = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Word hash as seen at the end of the name: a pending short word is folded in.
    always_comb begin
        if (take && r_pos == POS_LAST) begin
            n_word_hash = n_word_acc;
        end else if (n_pos != '0) begin
            n_word_hash = rotl1(r_word_acc) + t_hash'(n_partial);
        end else begin
            n_word_hash = r_word_acc;
        end
    end

    // State registers; a last item clears them for the next name.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_acc <= '0;
            r_byte_acc <= '0;
            r_partial  <= '0;
            r_pos      <= '0;
            r_len      <= '0;
        end else if (in_accept) begin
            if (i_last_byte) begin
                r_word_acc <= '0;
                r_byte_acc <= '0;
                r_partial  <= '0;
                r_pos      <= '0;
                r_len      <= '0;
            end else begin
                r_word_acc <= n_word_acc;
                r_byte_acc <= n_byte_acc;
                r_partial  <= n_partial;
                r_pos      <= n_pos;
                r_len      <= n_len;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_byte) begin
            r_word_hash <= n_word_hash;
            r_byte_hash <= n_byte_acc;
        end
    end

endmodule

>>> hdl/fhd_checker.sv
// Port-level assertions for the file name hash block and the bind that attaches them.
module fhd_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_last_byte,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input fhd_pkg::t_hash        o_word_hash,
    input fhd_pkg::t_hash        o_byte_hash
);
    import fhd_pkg::*;

    logic in_accept;
    logic out_stall;
    logic [2*HASH_W-1:0] out_payload;

    assign in_accept   = i_in_valid && o_in_ready;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_payload = {o_word_hash, o_byte_hash};

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its hashes.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> $stable(out_payload))
        else $error("result changed while stalled");

    // With no result pending the block takes input.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // The last item of a name yields a result in the next cycle.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_last_byte |=> o_out_valid)
        else $error("no result after last item");

    // An item that is not last produces no result of its own.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_last_byte && (!o_out_valid || i_out_ready) |=> !o_out_valid)
        else $error("result without last item");

endmodule

bind filename_hash_dual fhd_checker u_fhd_checker (.*);
